### hdl/ptx_pkg.sv
// ----------------------------------------------------------------------------
// ptx_pkg
// Shared types and constants for the point transform block.
// ----------------------------------------------------------------------------
package ptx_pkg;

   localparam int COORD_W   = 32;   // point, coefficient and clip value width
   localparam int ROW_W     = 64;   // one half-row register
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DIM_W = 13;   // bits of a size write that are kept

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_XROW_LO = 3'd0,
      CSR_XROW_HI = 3'd1,
      CSR_YROW_LO = 3'd2,
      CSR_YROW_HI = 3'd3,
      CSR_WROW_LO = 3'd4,
      CSR_WROW_HI = 3'd5,
      CSR_WIDTH   = 3'd6,
      CSR_HEIGHT  = 3'd7
   } csr_index_type;

   localparam logic [ROW_W-1:0] XROW_LO_RST = 64'h0000_0000_0001_0000;
   localparam logic [ROW_W-1:0] XROW_HI_RST = 64'h0;
   localparam logic [ROW_W-1:0] YROW_LO_RST = 64'h0001_0000_0000_0000;
   localparam logic [ROW_W-1:0] YROW_HI_RST = 64'h0;
   localparam logic [ROW_W-1:0] WROW_LO_RST = 64'h0;
   localparam logic [ROW_W-1:0] WROW_HI_RST = 64'h0001_0000_0000_0000;
   localparam int WIDTH_RST  = 640;
   localparam int HEIGHT_RST = 480;

endpackage

### hdl/ptx_div.sv
// ----------------------------------------------------------------------------
// ptx_div
// Pipelined restoring divider: one quotient bit per register stage.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module ptx_div #(
   parameter int NUM_W = 46,
   parameter int DEN_W = 33,
   parameter int QW    = 13
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QW-1:0]    quo
);

   logic [NUM_W-1:0] rem_ff [QW];
   logic [DEN_W-1:0] den_ff [QW];
   logic [QW-1:0]    quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QW-1:0]    quo_prev;
      logic [NUM_W-1:0] shifted;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign shifted = NUM_W'(den_prev) << (QW-1-k);
      assign ge      = rem_prev >= shifted;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? rem_prev - shifted : rem_prev;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_prev | (QW'(ge) << (QW-1-k));
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

### hdl/point_transform_project.sv
// ----------------------------------------------------------------------------
// point_transform_project
// Vertex transform, clip test and viewport map for Q16.16 points.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) takes one point pt_x, pt_y, pt_z
//   per cycle while req_stall is low. Response channel (rsp_valid/rsp_stall)
//   gives visible and the pixel (pix_x, pix_y), both zero for a rejected
//   point. One response per request, in order.
//   Configuration is written through csr_valid/csr_ready (always ready) with
//   csr_index selecting the register; write only while the block is empty.
//   Image sizes keep their low CSR_DIM_W bits on write; above MAX_DIM they saturate.
// Pipeline: multiply, sum and saturate, clip and scale, one stage per
//   quotient bit of the divider, and the output register.
// Throughput: one point per cycle while no response is held by rsp_stall;
//   the divider is fully pipelined.
// Reset: empties the pipeline and loads the identity-like default rows and a
//   640 x 480 image.
// Stall: while a response waits with rsp_stall high, the whole pipeline
//   holds and req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module point_transform_project
   import ptx_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int MAX_DIM   = 4096,
   localparam int DIM_W    = $clog2(MAX_DIM + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_pt_x,
   input  logic signed [COORD_W-1:0]  req_pt_y,
   input  logic signed [COORD_W-1:0]  req_pt_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_visible,
   output logic [DIM_W-1:0]           rsp_pix_x,
   output logic [DIM_W-1:0]           rsp_pix_y,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [ROW_W-1:0]           csr_wdata
);

   localparam int PROD_W = 2 * COORD_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int NUM_W  = COORD_W + 1 + DIM_W;
   localparam int DEN_W  = COORD_W + 1;
   localparam logic signed [COORD_W:0] NEAR_W =
      (COORD_W+1)'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

   // ---------------- configuration ----------------
   logic [ROW_W-1:0] row_ff [6];
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [CSR_DIM_W-1:0] dim_raw;
   logic [DIM_W-1:0]     dim_in;
   csr_index_type        csr_idx;

   assign csr_ready = 1'b1;
   assign csr_idx   = csr_index_type'(csr_index);
   assign dim_raw   = csr_wdata[CSR_DIM_W-1:0];
   always_comb begin
      if (32'(dim_raw) > 32'(MAX_DIM)) begin
         dim_in = DIM_W'(MAX_DIM);
      end else begin
         dim_in = DIM_W'(dim_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= XROW_LO_RST;
         row_ff[1] <= XROW_HI_RST;
         row_ff[2] <= YROW_LO_RST;
         row_ff[3] <= YROW_HI_RST;
         row_ff[4] <= WROW_LO_RST;
         row_ff[5] <= WROW_HI_RST;
         width_ff  <= DIM_W'(WIDTH_RST);
         height_ff <= DIM_W'(HEIGHT_RST);
      end else if (csr_valid && csr_ready) begin
         case (csr_idx)
            CSR_XROW_LO: row_ff[0] <= csr_wdata;
            CSR_XROW_HI: row_ff[1] <= csr_wdata;
            CSR_YROW_LO: row_ff[2] <= csr_wdata;
            CSR_YROW_HI: row_ff[3] <= csr_wdata;
            CSR_WROW_LO: row_ff[4] <= csr_wdata;
            CSR_WROW_HI: row_ff[5] <= csr_wdata;
            CSR_WIDTH:   width_ff  <= dim_in;
            CSR_HEIGHT:  height_ff <= dim_in;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage 1: products ----------------
   logic signed [PROD_W-1:0] prod_ff [9];
   logic                     v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_mul
      logic signed [COORD_W-1:0] cx, cy, cz;
      assign cx = row_ff[2*r][COORD_W-1:0];
      assign cy = row_ff[2*r][ROW_W-1:COORD_W];
      assign cz = row_ff[2*r+1][COORD_W-1:0];
      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[3*r]   <= PROD_W'(cx) * PROD_W'(req_pt_x);
            prod_ff[3*r+1] <= PROD_W'(cy) * PROD_W'(req_pt_y);
            prod_ff[3*r+2] <= PROD_W'(cz) * PROD_W'(req_pt_z);
         end
      end
   end

   // ---------------- stage 2: sum and saturate ----------------
   logic signed [COORD_W-1:0] clip_ff [3];
   logic                      v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_sum
      logic signed [SUM_W-1:0]   sum;
      logic signed [COORD_W-1:0] trans;
      assign trans = row_ff[2*r+1][ROW_W-1:COORD_W];
      // arithmetic shift rounds toward minus infinity
      assign sum = SUM_W'(prod_ff[3*r]   >>> FRAC_BITS)
                 + SUM_W'(prod_ff[3*r+1] >>> FRAC_BITS)
                 + SUM_W'(prod_ff[3*r+2] >>> FRAC_BITS)
                 + SUM_W'(trans);
      always_ff @(posedge clock) begin
         if (en) begin
            if (sum > SAT_MAX) begin
               clip_ff[r] <= COORD_W'(SAT_MAX);
            end else if (sum < SAT_MIN) begin
               clip_ff[r] <= COORD_W'(SAT_MIN);
            end else begin
               clip_ff[r] <= COORD_W'(sum);
            end
         end
      end
   end

   // ---------------- stage 3: clip test and scale ----------------
   logic signed [COORD_W:0] ex, ey, ew, sx, sy;
   logic                    vis;
   logic [NUM_W-1:0]        numx_ff, numy_ff;
   logic [DEN_W-1:0]        den_ff;
   logic                    v3_ff, vis3_ff;

   assign ex  = (COORD_W+1)'(clip_ff[0]);
   assign ey  = (COORD_W+1)'(clip_ff[1]);
   assign ew  = (COORD_W+1)'(clip_ff[2]);
   assign vis = (ew >= NEAR_W) && (ex >= -ew) && (ex <= ew) && (ey >= -ew) && (ey <= ew);
   assign sx  = ex + ew;
   assign sy  = ey + ew;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis3_ff <= vis;
         // zero the numerators of a rejected point and set its denominator to one
         numx_ff <= vis ? NUM_W'(unsigned'(sx)) * NUM_W'(width_ff)  : '0;
         numy_ff <= vis ? NUM_W'(unsigned'(sy)) * NUM_W'(height_ff) : '0;
         den_ff  <= vis ? DEN_W'(unsigned'(ew)) << 1 : DEN_W'(1);
      end
   end

   // ---------------- divide ----------------
   logic [DIM_W-1:0] quox, quoy;
   logic             vline_ff [DIM_W];
   logic             visline_ff [DIM_W];

   ptx_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(DIM_W)) u_div_x (
      .clock (clock), .en (en), .num (numx_ff), .den (den_ff), .quo (quox)
   );
   ptx_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(DIM_W)) u_div_y (
      .clock (clock), .en (en), .num (numy_ff), .den (den_ff), .quo (quoy)
   );

   for (genvar k = 0; k < DIM_W; k++) begin : g_vline
      always_ff @(posedge clock) begin
         if (reset) begin
            vline_ff[k] <= 1'b0;
         end else if (en) begin
            vline_ff[k] <= (k == 0) ? v3_ff : vline_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            visline_ff[k] <= (k == 0) ? vis3_ff : visline_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // ---------------- output register ----------------
   logic             rsp_valid_ff, rsp_visible_ff;
   logic [DIM_W-1:0] pix_x_ff, pix_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vline_ff[DIM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_visible_ff <= visline_ff[DIM_W-1];
         pix_x_ff       <= visline_ff[DIM_W-1] ? quox : '0;
         pix_y_ff       <= visline_ff[DIM_W-1] ? quoy : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;
   assign rsp_pix_x   = pix_x_ff;
   assign rsp_pix_y   = pix_y_ff;

   // ---------------- assertions ----------------
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_pix_x == '0 && rsp_pix_y == '0)
      else $error("rejected point with nonzero pixel");

   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |-> rsp_pix_x <= width_ff && rsp_pix_y <= height_ff)
      else $error("pixel beyond image size");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> rsp_valid)
      else $error("pipeline held without a waiting response");

endmodule
